/* rtl/sms_pkg.sv */
// Shared types, constants and helper functions for the softmax regression SGD block.
// No dependencies; every other file in rtl/ imports this package.
package sms_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int MAX_CLASSES  = 16;
    localparam int MAX_BATCH    = 64;

    localparam int FEAT_W = $clog2(MAX_FEATURES);
    localparam int CLS_W  = $clog2(MAX_CLASSES);
    localparam int SMP_W  = $clog2(MAX_BATCH);
    localparam int NCNT_W = $clog2(MAX_FEATURES + 1);
    localparam int KCNT_W = $clog2(MAX_CLASSES + 1);
    localparam int BCNT_W = $clog2(MAX_BATCH + 1);

    localparam int W_AW = $clog2(MAX_FEATURES * MAX_CLASSES);
    localparam int X_AW = $clog2(MAX_BATCH * MAX_FEATURES);
    localparam int P_AW = $clog2(MAX_BATCH * MAX_CLASSES);

    // Fixed field widths of the ports
    localparam int IDXF_W = 6;
    localparam int IDXC_W = 4;
    localparam int LBL_W  = 4;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam int CFGF_W = 7;
    localparam int CFGK_W = 5;
    localparam int CFGB_W = 7;
    localparam int RATE_W = 16;

    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = $clog2(Q_DEPTH);

    localparam int ACC_W  = 56;
    localparam int DIV_NW = 42;
    localparam int DIV_DW = 22;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;
    localparam logic [31:0]        ONE_Q16   = 32'd65536;

    typedef enum logic [1:0] {
        KIND_WR_W  = 2'd0,
        KIND_FEAT  = 2'd1,
        KIND_RD_W  = 2'd2,
        KIND_EPOCH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_FEATURES = 2'd0,
        CFG_CLASSES  = 2'd1,
        CFG_BATCH    = 2'd2,
        CFG_RATE     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_WR_W = 2'd0,
        OP_RD_W = 2'd1,
        OP_FEAT = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              in_store;
        logic [W_AW-1:0]   widx;
        logic [X_AW-1:0]   xaddr;
        logic [SMP_W-1:0]  sidx;
        logic [31:0]       value;
        logic [LBL_W-1:0]  label;
        logic              apply;
    } cmd_t;

    typedef struct packed {
        logic [NCNT_W-1:0] n;
        logic [KCNT_W-1:0] k;
        logic [BCNT_W-1:0] b;
        logic [RATE_W-1:0] lr;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_OUT,
        ST_L_RD,
        ST_L_MUL,
        ST_L_ACC,
        ST_L_WR,
        ST_E_RD,
        ST_E_MUL1,
        ST_E_MUL2,
        ST_E_WR,
        ST_D_RD,
        ST_D_START,
        ST_D_WAIT,
        ST_U_RD,
        ST_U_MUL,
        ST_U_ACC,
        ST_U_Q1,
        ST_U_Q2,
        ST_U_DIV,
        ST_DONE
    } eng_state_t;

    // 2^(i/16) in Q16.16
    function automatic logic [17:0] pow2_q16(input logic [4:0] i);
        logic [17:0] r;
        case (i)
            5'd0:    r = 18'd65536;
            5'd1:    r = 18'd68438;
            5'd2:    r = 18'd71468;
            5'd3:    r = 18'd74632;
            5'd4:    r = 18'd77936;
            5'd5:    r = 18'd81386;
            5'd6:    r = 18'd84990;
            5'd7:    r = 18'd88752;
            5'd8:    r = 18'd92682;
            5'd9:    r = 18'd96785;
            5'd10:   r = 18'd101070;
            5'd11:   r = 18'd105545;
            5'd12:   r = 18'd110218;
            5'd13:   r = 18'd115098;
            5'd14:   r = 18'd120194;
            5'd15:   r = 18'd125515;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* rtl/softmax_regression_sgd.sv */
// Top level of the softmax regression minibatch SGD block.
// Depends on sms_pkg, sms_front, sms_fifo and sms_engine (which holds sms_div).
//
//  channel   direction  handshake            payload
//  cfg       in         cfg_we               cfg_index, cfg_data
//  in        in         in_valid / in_stall  kind, feature_index, class_index, value, label
//  out       out        out_valid / out_stall read_value, batch_applied
//
// Weight writes and buffered feature elements are handled as the engine pops them; a weight
// read delivers its transaction through the read-out state and the output register.
// The length of a batch update is set by the one shared 32x32 multiplier, which does
// every MAC, and by the serial divider.
// A four-entry queue keeps accepting input while the engine works or the output stalls.
// Reset clears control state only; memories hold nothing valid until written.
module softmax_regression_sgd (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sms_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [sms_pkg::CFG_DW-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [sms_pkg::IDXF_W-1:0]    feature_index,
    input  logic [sms_pkg::IDXC_W-1:0]    class_index,
    input  logic signed [31:0]            value,
    input  logic [sms_pkg::LBL_W-1:0]     label,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            read_value,
    output logic                          batch_applied
);
    import sms_pkg::*;

    cfg_t cfg;
    cmd_t q_wdata, q_rdata;
    logic q_push, q_full, q_pop, q_not_empty;

    sms_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .feature_index (feature_index),
        .class_index   (class_index),
        .value         (value),
        .label         (label),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata),
        .cfg           (cfg)
    );

    sms_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty)
    );

    sms_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .head_valid    (q_not_empty),
        .head          (q_rdata),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_value    (read_value),
        .batch_applied (batch_applied)
    );

endmodule

/* rtl/sms_div.sv */
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on sms_pkg for operand widths.
module sms_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sms_pkg::DIV_NW-1:0]  dividend,
    input  logic [sms_pkg::DIV_DW-1:0]  divisor,
    output logic                        done,
    output logic [sms_pkg::DIV_NW-1:0]  quotient,
    output logic [sms_pkg::DIV_DW-1:0]  remainder
);
    import sms_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_NW-1:0] num_reg, num_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_DW:0]   trial;
    logic              fits;

    assign trial = {rem_reg, num_reg[DIV_NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
            num_next = {num_reg[DIV_NW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/sms_engine.sv */
// Back end: weight, feature, label and probability memories and the batch sequencer.
// Depends on sms_pkg and sms_div; fed from the command queue.
module sms_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  sms_pkg::cfg_t       cfg,
    input  logic                head_valid,
    input  sms_pkg::cmd_t       head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  read_value,
    output logic                batch_applied
);
    import sms_pkg::*;

    eng_state_t state_reg, state_next;

    logic [FEAT_W-1:0] f_reg;
    logic [CLS_W-1:0]  c_reg;
    logic [SMP_W-1:0]  s_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [63:0]      prod_reg;
    logic signed [31:0]      max_reg;
    logic [DIV_DW-1:0]       sum_reg;
    logic signed [39:0]      tprod_reg;
    logic                    dz_reg;
    logic [24:0]             fp_reg;
    logic [3:0]              idx_reg;
    logic [4:0]              shift_reg;
    logic                    ezero_reg;
    logic [31:0]             pp_lo_reg;
    logic signed [40:0]      pp_hi_reg;
    logic                    neg_reg;
    logic signed [31:0]      w_old_reg;
    logic                    rd_in_store_reg;

    logic                    out_valid_reg;
    logic signed [31:0]      read_value_reg;
    logic                    batch_applied_reg;

    // Memories
    logic [31:0]      w_mem [MAX_FEATURES*MAX_CLASSES];
    logic [31:0]      x_mem [MAX_BATCH*MAX_FEATURES];
    logic [31:0]      p_mem [MAX_BATCH*MAX_CLASSES];
    logic [LBL_W-1:0] l_mem [MAX_BATCH];

    logic              w_we, x_we, p_we, l_we;
    logic [W_AW-1:0]   w_waddr, w_raddr;
    logic [X_AW-1:0]   x_waddr, x_raddr;
    logic [P_AW-1:0]   p_waddr, p_raddr;
    logic [SMP_W-1:0]  l_waddr;
    logic [31:0]       w_wdata, x_wdata, p_wdata;
    logic [LBL_W-1:0]  l_wdata;
    logic signed [31:0] w_rdata, x_rdata, p_rdata;
    logic [LBL_W-1:0]  l_rdata;

    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_quo;
    logic [DIV_DW-1:0] div_den, div_rem;

    logic              out_free, out_load, out_flag;
    logic signed [31:0] out_rd;

    logic last_f, last_c, last_s;
    logic [X_AW-1:0] x_addr;
    logic [W_AW-1:0] w_addr_loop;
    logic [P_AW-1:0] p_addr;

    logic signed [31:0]      mul_b;
    logic signed [63:0]      mul_p;
    logic signed [ACC_W-1:0] acc_l_next, acc_u_next;
    logic signed [31:0]      logit_sat;
    logic signed [32:0]      d_val;
    logic                    dz_c;
    logic signed [21:0]      d_cl;
    logic signed [39:0]      tprod_c;
    logic signed [23:0]      t_val;
    logic signed [7:0]       ip_val, nip_val;
    logic [15:0]             fr_val;
    logic [17:0]             diff_val;
    logic [24:0]             fp_c;
    logic [17:0]             v_val, e_val;
    logic [DIV_DW-1:0]       sum_next;
    logic                    is_lbl;
    logic signed [31:0]      g_val;
    logic [31:0]             pp_lo_c;
    logic signed [23:0]      q_hi;
    logic signed [40:0]      pp_hi_c;
    logic signed [41:0]      p16;
    logic [41:0]             mag;
    logic [42:0]             qadj;
    logic signed [43:0]      delta, wdiff;
    logic signed [31:0]      w_new;

    sms_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_waddr] <= w_wdata;
        w_rdata <= w_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[x_waddr] <= x_wdata;
        x_rdata <= x_mem[x_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            p_mem[p_waddr] <= p_wdata;
        p_rdata <= p_mem[p_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
            l_mem[l_waddr] <= l_wdata;
        l_rdata <= l_mem[s_reg];
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign last_f = (NCNT_W'(f_reg) + NCNT_W'(1)) == cfg.n;
    assign last_c = (KCNT_W'(c_reg) + KCNT_W'(1)) == cfg.k;
    assign last_s = (BCNT_W'(s_reg) + BCNT_W'(1)) == cfg.b;

    assign x_addr      = X_AW'(s_reg * MAX_FEATURES + f_reg);
    assign w_addr_loop = W_AW'(f_reg * MAX_CLASSES + c_reg);
    assign p_addr      = P_AW'(s_reg * MAX_CLASSES + c_reg);

    // Shared multiplier: logits take weights, the gradient takes probabilities
    assign mul_b = (state_reg == ST_U_MUL) ? p_rdata : w_rdata;
    assign mul_p = x_rdata * mul_b;

    assign acc_l_next = acc_reg + ACC_W'(prod_reg >>> 16);
    assign acc_u_next = acc_reg + ACC_W'(prod_reg);
    assign logit_sat  = sat32(64'(acc_reg));

    // Exp after subtracting the row maximum; far negative differences give zero
    assign d_val    = 33'(p_rdata) - 33'(max_reg);
    assign dz_c     = d_val < -33'sd2097152;
    assign d_cl     = d_val[21:0];
    assign tprod_c  = d_cl * LOG2E_Q16;
    assign t_val    = tprod_reg[39:16];
    assign ip_val   = t_val[23:16];
    assign nip_val  = -ip_val;
    assign fr_val   = t_val[15:0];
    assign diff_val = pow2_q16({1'b0, fr_val[15:12]} + 5'd1) - pow2_q16({1'b0, fr_val[15:12]});
    assign fp_c     = diff_val[12:0] * fr_val[11:0];
    assign v_val    = pow2_q16({1'b0, idx_reg}) + 18'(fp_reg >> 12);
    assign e_val    = ezero_reg ? 18'd0 : (v_val >> shift_reg);
    assign sum_next = sum_reg + DIV_DW'(e_val);

    assign is_lbl = 32'(l_rdata) == 32'(c_reg);
    assign g_val  = $signed(32'(div_quo[16:0])) - (is_lbl ? $signed(ONE_Q16) : 32'sd0);

    assign pp_lo_c = acc_reg[31:16] * cfg.lr;
    assign q_hi    = acc_reg[55:32];
    assign pp_hi_c = q_hi * $signed({1'b0, cfg.lr});
    assign p16     = 42'(pp_hi_reg) + $signed({26'd0, pp_lo_reg[31:16]});
    assign mag     = p16[41] ? 42'(-p16) : 42'(p16);
    // Round the magnitude up only for a negative step, so both signs floor
    assign qadj    = {1'b0, div_quo} + 43'(div_rem != '0);
    assign delta   = neg_reg ? -$signed({1'b0, qadj}) : $signed({2'b0, div_quo});
    assign wdiff   = 44'(w_old_reg) - delta;
    assign w_new   = sat32(64'(wdiff));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    if (head.op == OP_RD_W)
                        state_next = ST_RD_OUT;
                    else if (head.op == OP_FEAT && head.apply)
                        state_next = ST_L_RD;
                end
            end
            ST_RD_OUT:  state_next = ST_IDLE;
            ST_L_RD:    state_next = ST_L_MUL;
            ST_L_MUL:   state_next = ST_L_ACC;
            ST_L_ACC:   state_next = last_f ? ST_L_WR : ST_L_RD;
            ST_L_WR:    state_next = last_c ? ST_E_RD : ST_L_RD;
            ST_E_RD:    state_next = ST_E_MUL1;
            ST_E_MUL1:  state_next = ST_E_MUL2;
            ST_E_MUL2:  state_next = ST_E_WR;
            ST_E_WR:    state_next = last_c ? ST_D_RD : ST_E_RD;
            ST_D_RD:    state_next = ST_D_START;
            ST_D_START: state_next = ST_D_WAIT;
            ST_D_WAIT:
            begin
                if (div_done)
                begin
                    if (!last_c)
                        state_next = ST_D_RD;
                    else
                        state_next = last_s ? ST_U_RD : ST_L_RD;
                end
            end
            ST_U_RD:    state_next = ST_U_MUL;
            ST_U_MUL:   state_next = ST_U_ACC;
            ST_U_ACC:   state_next = last_s ? ST_U_Q1 : ST_U_RD;
            ST_U_Q1:    state_next = ST_U_Q2;
            ST_U_Q2:    state_next = ST_U_DIV;
            ST_U_DIV:
            begin
                if (div_done)
                    state_next = (last_c && last_f) ? ST_DONE : ST_U_RD;
            end
            ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        w_we      = 1'b0;
        w_waddr   = head.widx;
        w_wdata   = head.value;
        w_raddr   = w_addr_loop;
        x_we      = 1'b0;
        x_waddr   = head.xaddr;
        x_wdata   = head.value;
        x_raddr   = x_addr;
        l_we      = 1'b0;
        l_waddr   = head.sidx;
        l_wdata   = head.label;
        p_we      = 1'b0;
        p_waddr   = p_addr;
        p_wdata   = '0;
        p_raddr   = p_addr;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        out_load  = 1'b0;
        out_rd    = '0;
        out_flag  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    pop = 1'b1;
                    case (head.op)
                        OP_WR_W: w_we = head.in_store;
                        OP_RD_W: w_raddr = head.widx;
                        OP_FEAT:
                        begin
                            x_we = 1'b1;
                            l_we = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_OUT:
            begin
                out_load = 1'b1;
                out_rd   = rd_in_store_reg ? w_rdata : 32'sd0;
            end
            ST_L_WR:
            begin
                p_we    = 1'b1;
                p_wdata = logit_sat;
            end
            ST_E_WR:
            begin
                p_we    = 1'b1;
                p_wdata = 32'(e_val);
            end
            ST_D_START:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'({p_rdata[17:0], 16'd0});
                div_den   = sum_reg;
            end
            ST_D_WAIT:
            begin
                if (div_done)
                begin
                    p_we    = 1'b1;
                    p_wdata = g_val;
                end
            end
            ST_U_Q2:
            begin
                div_start = 1'b1;
                div_num   = mag;
                div_den   = DIV_DW'(cfg.b);
            end
            ST_U_DIV:
            begin
                if (div_done)
                begin
                    w_we    = 1'b1;
                    w_waddr = w_addr_loop;
                    w_wdata = w_new;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_flag = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_value_reg    <= out_rd;
            batch_applied_reg <= out_flag;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_in_store_reg <= head.in_store;
                s_reg   <= '0;
                c_reg   <= '0;
                f_reg   <= '0;
                acc_reg <= '0;
            end
            ST_L_MUL, ST_U_MUL:
                prod_reg <= mul_p;
            ST_L_ACC:
            begin
                acc_reg <= acc_l_next;
                if (!last_f)
                    f_reg <= f_reg + 1'b1;
            end
            ST_L_WR:
            begin
                f_reg   <= '0;
                acc_reg <= '0;
                if (c_reg == '0 || logit_sat > max_reg)
                    max_reg <= logit_sat;
                if (last_c)
                begin
                    c_reg   <= '0;
                    sum_reg <= '0;
                end
                else
                    c_reg <= c_reg + 1'b1;
            end
            ST_E_MUL1:
            begin
                tprod_reg <= tprod_c;
                dz_reg    <= dz_c;
            end
            ST_E_MUL2:
            begin
                fp_reg    <= fp_c;
                idx_reg   <= fr_val[15:12];
                shift_reg <= nip_val[4:0];
                ezero_reg <= dz_reg || (ip_val < -8'sd16);
            end
            ST_E_WR:
            begin
                sum_reg <= sum_next;
                c_reg   <= last_c ? '0 : c_reg + 1'b1;
            end
            ST_D_WAIT:
            begin
                if (div_done)
                begin
                    if (last_c)
                    begin
                        c_reg <= '0;
                        s_reg <= last_s ? '0 : s_reg + 1'b1;
                    end
                    else
                        c_reg <= c_reg + 1'b1;
                end
            end
            ST_U_ACC:
            begin
                acc_reg <= acc_u_next;
                s_reg   <= last_s ? '0 : s_reg + 1'b1;
            end
            ST_U_Q1:
            begin
                pp_lo_reg <= pp_lo_c;
                pp_hi_reg <= pp_hi_c;
            end
            ST_U_Q2:
            begin
                neg_reg   <= p16[41];
                w_old_reg <= w_rdata;
            end
            ST_U_DIV:
            begin
                if (div_done)
                begin
                    acc_reg <= '0;
                    if (last_c)
                    begin
                        c_reg <= '0;
                        f_reg <= last_f ? '0 : f_reg + 1'b1;
                    end
                    else
                        c_reg <= c_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign read_value    = read_value_reg;
    assign batch_applied = batch_applied_reg;

endmodule

/* rtl/sms_front.sv */
// Front end: configuration registers, input decode and sample/batch position tracking.
// Depends on sms_pkg; pushes commands into the queue ahead of the engine.
module sms_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sms_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [sms_pkg::CFG_DW-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [sms_pkg::IDXF_W-1:0]    feature_index,
    input  logic [sms_pkg::IDXC_W-1:0]    class_index,
    input  logic signed [31:0]            value,
    input  logic [sms_pkg::LBL_W-1:0]     label,
    input  logic                          q_full,
    output logic                          q_push,
    output sms_pkg::cmd_t                 q_data,
    output sms_pkg::cfg_t                 cfg
);
    import sms_pkg::*;

    logic [CFGF_W-1:0] feat_reg;
    logic [CFGK_W-1:0] cls_reg;
    logic [CFGB_W-1:0] batch_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [FEAT_W-1:0] fc_reg, fc_next;
    logic [SMP_W-1:0]  sc_reg, sc_next;

    logic              accept;
    logic [NCNT_W-1:0] fc_inc;
    logic [BCNT_W-1:0] sc_inc;
    logic              sample_end, batch_end;

    // Clamp the registers to their legal ranges
    always_comb
    begin
        cfg.n  = (feat_reg == '0) ? NCNT_W'(1) :
                 ((32'(feat_reg) > MAX_FEATURES) ? NCNT_W'(MAX_FEATURES) : NCNT_W'(feat_reg));
        cfg.k  = (32'(cls_reg) < 2) ? KCNT_W'(2) :
                 ((32'(cls_reg) > MAX_CLASSES) ? KCNT_W'(MAX_CLASSES) : KCNT_W'(cls_reg));
        cfg.b  = (batch_reg == '0) ? BCNT_W'(1) :
                 ((32'(batch_reg) > MAX_BATCH) ? BCNT_W'(MAX_BATCH) : BCNT_W'(batch_reg));
        cfg.lr = rate_reg;
    end

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign fc_inc     = NCNT_W'(fc_reg) + NCNT_W'(1);
    assign sc_inc     = BCNT_W'(sc_reg) + BCNT_W'(1);
    assign sample_end = fc_inc >= cfg.n;
    assign batch_end  = sample_end && (sc_inc >= cfg.b);

    always_comb
    begin
        q_data.in_store = (32'(feature_index) < MAX_FEATURES) && (32'(class_index) < MAX_CLASSES);
        q_data.widx     = W_AW'(feature_index * MAX_CLASSES + class_index);
        q_data.xaddr    = X_AW'(sc_reg * MAX_FEATURES + fc_reg);
        q_data.sidx     = sc_reg;
        q_data.value    = value;
        q_data.label    = label;
        q_data.apply    = batch_end;
        q_push          = accept;
        unique case (kind)
            KIND_WR_W: q_data.op = OP_WR_W;
            KIND_RD_W: q_data.op = OP_RD_W;
            KIND_FEAT: q_data.op = OP_FEAT;
            default:
            begin
                q_data.op = OP_FEAT;
                q_push    = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        fc_next = fc_reg;
        sc_next = sc_reg;
        if (accept)
        begin
            case (kind)
                KIND_EPOCH:
                begin
                    fc_next = '0;
                    sc_next = '0;
                end
                KIND_FEAT:
                begin
                    if (sample_end)
                    begin
                        fc_next = '0;
                        sc_next = batch_end ? '0 : SMP_W'(sc_inc);
                    end
                    else
                        fc_next = FEAT_W'(fc_inc);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feat_reg  <= CFGF_W'(64);
            cls_reg   <= CFGK_W'(16);
            batch_reg <= CFGB_W'(64);
            rate_reg  <= RATE_W'(655);
            fc_reg    <= '0;
            sc_reg    <= '0;
        end
        else
        begin
            fc_reg <= fc_next;
            sc_reg <= sc_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FEATURES: feat_reg  <= cfg_data[CFGF_W-1:0];
                    CFG_CLASSES:  cls_reg   <= cfg_data[CFGK_W-1:0];
                    CFG_BATCH:    batch_reg <= cfg_data[CFGB_W-1:0];
                    CFG_RATE:     rate_reg  <= cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* rtl/sms_fifo.sv */
// Short show-ahead command queue between the front end and the engine.
// Depends on sms_pkg for the command type and depth.
module sms_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sms_pkg::cmd_t   wdata,
    output logic            full,
    input  logic            pop,
    output sms_pkg::cmd_t   rdata,
    output logic            not_empty
);
    import sms_pkg::*;

    cmd_t            q_mem [Q_DEPTH];
    logic [Q_PW-1:0] wr_reg, rd_reg;
    logic [Q_PW:0]   cnt_reg;
    logic            do_push, do_pop;

    assign full      = cnt_reg == (Q_PW+1)'(Q_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = q_mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (32'(wr_reg) == Q_DEPTH - 1) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (32'(rd_reg) == Q_DEPTH - 1) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* bench/sms_checker.sv */
// Checker for softmax_regression_sgd: watches the config port and both channels,
// predicts every result in Q16.16 and compares it with what the block delivers.
// Depends on sms_pkg for the input kind and register index codes.
module sms_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sms_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [sms_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [1:0]                  kind,
    input  logic [sms_pkg::IDXF_W-1:0]  feature_index,
    input  logic [sms_pkg::IDXC_W-1:0]  class_index,
    input  logic signed [31:0]          value,
    input  logic [sms_pkg::LBL_W-1:0]   label,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic signed [31:0]          read_value,
    input  logic                        batch_applied,
    output int                          errors,
    output int                          pending,
    output int                          reads_seen,
    output int                          batches_seen
);
    import sms_pkg::*;

    typedef struct {
        logic signed [31:0] rv;
        logic               ba;
    } sgd_result_t;

    localparam longint EXP2_TAB [0:16] = '{
        65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
        96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};

    sgd_result_t        result_q[$];
    logic signed [31:0] weights [0:MAX_FEATURES*MAX_CLASSES-1];
    logic signed [31:0] feat_buf [0:MAX_BATCH*MAX_FEATURES-1];
    logic [LBL_W-1:0]   label_buf [0:MAX_BATCH-1];
    int                 feat_pos;
    int                 sample_cnt;
    logic [CFGF_W-1:0]  reg_n;
    logic [CFGK_W-1:0]  reg_k;
    logic [CFGB_W-1:0]  reg_b;
    logic [RATE_W-1:0]  reg_lr;

    function automatic longint clampi(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sat_q(longint v);
        return clampi(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // 2^(d*log2 e) with a 16-segment linear table, d <= 0
    function automatic longint exp_fix(longint d);
        longint t, ip, v;
        longint fr, seg, r;
        t   = (d * 94548) >>> 16;
        ip  = t >>> 16;
        fr  = t & 64'hFFFF;
        seg = fr >> 12;
        r   = fr & 4095;
        if (ip < -16)
            return 0;
        v = EXP2_TAB[seg] + (((EXP2_TAB[seg+1] - EXP2_TAB[seg]) * r) >>> 12);
        return v >>> (-ip);
    endfunction

    task automatic apply_sgd_step(int n, int k, int b);
        longint grad [0:MAX_BATCH-1][0:MAX_CLASSES-1];
        longint acc, mx, total, g, q, delta;
        for (int s = 0; s < b; s++)
        begin
            for (int c = 0; c < k; c++)
            begin
                acc = 0;
                for (int f = 0; f < n; f++)
                    acc += (longint'(feat_buf[s*MAX_FEATURES+f]) *
                            weights[f*MAX_CLASSES+c]) >>> 16;
                grad[s][c] = sat_q(acc);
            end
            mx = grad[s][0];
            for (int c = 1; c < k; c++)
                if (grad[s][c] > mx)
                    mx = grad[s][c];
            total = 0;
            for (int c = 0; c < k; c++)
            begin
                grad[s][c] = exp_fix(grad[s][c] - mx);
                total += grad[s][c];
            end
            for (int c = 0; c < k; c++)
            begin
                grad[s][c] = (grad[s][c] * 65536) / total;
                if (c == label_buf[s])
                    grad[s][c] -= 65536;
            end
        end
        for (int f = 0; f < n; f++)
            for (int c = 0; c < k; c++)
            begin
                g = 0;
                for (int s = 0; s < b; s++)
                    g += longint'(feat_buf[s*MAX_FEATURES+f]) * grad[s][c];
                q = g >>> 16;
                delta = floor_div(q * longint'(reg_lr), longint'(b) * 65536);
                weights[f*MAX_CLASSES+c] = 32'(sat_q(weights[f*MAX_CLASSES+c] - delta));
            end
    endtask

    task automatic predict(logic [1:0] kd, logic [IDXF_W-1:0] fi, logic [IDXC_W-1:0] ci,
                           logic signed [31:0] v, logic [LBL_W-1:0] lb);
        sgd_result_t r;
        int n, k, b;
        n = int'(clampi(longint'(reg_n), 1, MAX_FEATURES));
        k = int'(clampi(longint'(reg_k), 2, MAX_CLASSES));
        b = int'(clampi(longint'(reg_b), 1, MAX_BATCH));
        case (kind_t'(kd))
            KIND_WR_W:
                weights[fi*MAX_CLASSES+ci] = v;
            KIND_RD_W:
            begin
                r.rv = weights[fi*MAX_CLASSES+ci];
                r.ba = 1'b0;
                result_q.push_back(r);
            end
            KIND_EPOCH:
            begin
                feat_pos   = 0;
                sample_cnt = 0;
            end
            default:
            begin
                if (feat_pos < MAX_FEATURES)
                    feat_buf[sample_cnt*MAX_FEATURES+feat_pos] = v;
                label_buf[sample_cnt] = lb;
                feat_pos++;
                if (feat_pos >= n)
                begin
                    feat_pos = 0;
                    sample_cnt++;
                    if (sample_cnt >= b)
                    begin
                        apply_sgd_step(n, k, b);
                        sample_cnt = 0;
                        r.rv = '0;
                        r.ba = 1'b1;
                        result_q.push_back(r);
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sgd_result_t want;
        if (!rst_n)
        begin
            result_q.delete();
            feat_pos     = 0;
            sample_cnt   = 0;
            reg_n        = 7'd64;
            reg_k        = 5'd16;
            reg_b        = 7'd64;
            reg_lr       = 16'd655;
            errors       = 0;
            pending      = 0;
            reads_seen   = 0;
            batches_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected transaction: read_value %0d batch_applied %0b",
                           read_value, batch_applied);
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (read_value !== want.rv)
                    begin
                        $error("read_value: expected %0d, got %0d", want.rv, read_value);
                        errors++;
                    end
                    if (batch_applied !== want.ba)
                    begin
                        $error("batch_applied: expected %0b, got %0b",
                               want.ba, batch_applied);
                        errors++;
                    end
                    if (want.ba)
                        batches_seen++;
                    else
                        reads_seen++;
                end
            end
            if (cfg_we)
                case (cfg_idx_t'(cfg_index))
                    CFG_FEATURES: reg_n  = cfg_data[CFGF_W-1:0];
                    CFG_CLASSES:  reg_k  = cfg_data[CFGK_W-1:0];
                    CFG_BATCH:    reg_b  = cfg_data[CFGB_W-1:0];
                    CFG_RATE:     reg_lr = cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            if (in_valid && !in_stall)
                predict(kind, feature_index, class_index, value, label);
            pending = result_q.size();
        end
    end

endmodule

/* bench/tb_softmax_regression_sgd.sv */
// Testbench top for softmax_regression_sgd: clock, reset, stimulus and verdict.
// Depends on sms_pkg, the RTL of the block and bench/sms_checker.sv.
module tb_softmax_regression_sgd;
    import sms_pkg::*;

    localparam int IDLE_LIMIT = 400000;
    localparam int N_PHASES   = 10;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          kind;
    logic [IDXF_W-1:0]   feature_index;
    logic [IDXC_W-1:0]   class_index;
    logic signed [31:0]  value;
    logic [LBL_W-1:0]    label;
    logic                out_valid;
    logic                out_stall;
    logic signed [31:0]  read_value;
    logic                batch_applied;

    int   errors, pending, reads_seen, batches_seen;
    int   idle_cycles;
    int   items_sent;
    int   idle_mode;
    logic hold_req;
    logic hold_seen;
    int   hold_left;
    int   cur_n;
    int   cur_k;
    logic [LBL_W-1:0] cur_label;

    softmax_regression_sgd dut (.*);

    sms_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: long hold-off on request, otherwise random stalls by mode
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            hold_seen <= hold_req;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (hold_req && !hold_seen)
            begin
                out_stall <= 1'b1;
                hold_left <= 400;
            end
            else if (idle_mode == 2)
                out_stall <= ($urandom_range(99) < 79);
            else if (idle_mode == 3)
                out_stall <= ($urandom_range(99) < 27);
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(kind_t kd, int fi, int ci, logic [31:0] v, int lb);
        while ((idle_mode == 1 && $urandom_range(99) < 79) ||
               (idle_mode == 3 && $urandom_range(99) < 27))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= kd;
        feature_index <= IDXF_W'(fi);
        class_index   <= IDXC_W'(ci);
        value         <= v;
        label         <= LBL_W'(lb);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Wait for every result, then let queued no-result items clear the block
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_regs(logic [15:0] n, logic [15:0] k, logic [15:0] b,
                              logic [15:0] lr);
        logic [15:0] vals [4];
        vals = '{n, k, b, lr};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_n = (n[6:0] < 1) ? 1 : ((n[6:0] > 64) ? 64 : n[6:0]);
        cur_k = (k[4:0] < 2) ? 2 : ((k[4:0] > 16) ? 16 : k[4:0]);
    endtask

    function automatic logic [31:0] rand_q16();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return $urandom;
        if (r < 13)
            return 32'h7FFFFFFF;
        if (r < 16)
            return 32'h80000000;
        return $urandom_range(524288) - 262144;
    endfunction

    task automatic rand_item();
        int r;
        r = $urandom_range(99);
        if (r < 72)
        begin
            // hold the label for most of a sample; sometimes pick one past the classes
            if ($urandom_range(99) < 15)
                cur_label = LBL_W'(($urandom_range(9) == 0) ? $urandom_range(15)
                                                            : $urandom_range(cur_k - 1));
            send(KIND_FEAT, $urandom, $urandom, rand_q16(), int'(cur_label));
        end
        else if (r < 85)
            send(KIND_RD_W, $urandom, $urandom, $urandom, $urandom);
        else if (r < 96)
            send(KIND_WR_W, $urandom, $urandom, rand_q16(), $urandom);
        else
            send(KIND_EPOCH, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        logic [15:0] ph_n [N_PHASES];
        logic [15:0] ph_k [N_PHASES];
        logic [15:0] ph_b [N_PHASES];
        logic [15:0] ph_lr [N_PHASES];
        int new_n;
        ph_n  = '{16'hFFC0, 0, 1, 127, 3, 2, 0, 0, 0, 0};
        ph_k  = '{16'hFFF0, 0, 16, 31, 4, 2, 0, 0, 0, 0};
        ph_b  = '{1, 0, 64, 1, 2, 3, 0, 0, 0, 0};
        ph_lr = '{16'hFFFF, 0, 655, 40000, 12000, 65535, 0, 0, 0, 0};
        for (int p = 6; p < N_PHASES; p++)
        begin
            ph_n[p]  = 16'($urandom_range(8, 1));
            ph_k[p]  = 16'($urandom_range(16, 2));
            ph_b[p]  = 16'($urandom_range(6, 1));
            ph_lr[p] = 16'($urandom);
        end
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        kind          = '0;
        feature_index = '0;
        class_index   = '0;
        value         = '0;
        label         = '0;
        hold_req      = 1'b0;
        idle_mode     = 0;
        items_sent    = 0;
        idle_cycles   = 0;
        cur_n         = 64;
        cur_k         = 16;
        cur_label     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole weight store so that no read ever sees an unwritten entry
        for (int f = 0; f < MAX_FEATURES; f++)
            for (int c = 0; c < MAX_CLASSES; c++)
                send(KIND_WR_W, f, c, $urandom_range(131072) - 65536, 0);

        // Directed: store extremes, saturated features, odd labels, dropped batch
        send(KIND_WR_W, 0, 0, 32'h7FFFFFFF, 0);
        send(KIND_WR_W, 63, 15, 32'h80000000, 0);
        send(KIND_RD_W, 0, 0, '0, 0);
        send(KIND_RD_W, 63, 15, 32'hFFFFFFFF, 15);
        send(KIND_WR_W, 0, 0, 32'h00010000, 0);
        send(KIND_WR_W, 63, 15, 32'hFFFF0000, 0);
        drain();
        write_regs(16'd2, 16'd2, 16'd1, 16'hFFFF);
        send(KIND_FEAT, 0, 0, 32'h7FFFFFFF, 15);
        send(KIND_FEAT, 0, 0, 32'h80000000, 15);
        send(KIND_FEAT, 0, 0, 32'h00020000, 0);
        send(KIND_FEAT, 0, 0, 32'hFFFE8000, 1);
        send(KIND_FEAT, 0, 0, 32'h00010000, 1);
        send(KIND_EPOCH, 0, 0, '0, 0);
        send(KIND_FEAT, 0, 0, 32'h00008000, 0);
        send(KIND_FEAT, 0, 0, 32'h00000000, 0);
        send(KIND_RD_W, 0, 0, '0, 0);
        send(KIND_RD_W, 0, 1, '0, 0);
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            new_n = (ph_n[p][6:0] < 1) ? 1 : ((ph_n[p][6:0] > 64) ? 64 : ph_n[p][6:0]);
            // a shrinking feature count may change mid-batch; otherwise start clean
            if (!(p % 2 == 1 && new_n <= cur_n))
            begin
                send(KIND_EPOCH, 0, 0, '0, 0);
                drain();
            end
            write_regs(ph_n[p], ph_k[p], ph_b[p], ph_lr[p]);
            idle_mode = p % 4;
            if (p == 4)
            begin
                // hold the receiver off while reads pile up behind it
                idle_mode = 0;
                hold_req <= 1'b1;
                for (int i = 0; i < 30; i++)
                    send(KIND_RD_W, $urandom, $urandom, '0, 0);
                hold_req <= 1'b0;
                drain();
            end
            for (int i = 0; i < 45; i++)
                rand_item();
            drain();
        end

        idle_mode = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Covered %0d transactions over %0d register settings and four idling modes:",
                 items_sent, N_PHASES + 1);
        $display("%0d weight reads and %0d batch updates checked", reads_seen, batches_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
